// ----- src/bbrgb_pkg.sv -----
// ---------------------------------------------------------------------------
// bbrgb_pkg - shared types and constants for the color temperature to RGB core
// Fixed-point formats, Horner coefficient table and region flags.
// ---------------------------------------------------------------------------
package bbrgb_pkg;

	// field and datapath widths
	localparam int T_W      = 16;   // temperature in kelvin
	localparam int X_W      = 23;   // x = T/1000, unsigned Q7.16 (max ~65.5)
	localparam int ACC_W    = 40;   // Horner accumulator, signed Q15.24
	localparam int COEF_W   = 29;   // coefficients, signed Q4.24
	localparam int LVL_W    = 16;   // channel level, signed Q3.12
	localparam int NUM_CH   = 3;
	localparam int ORDER    = 5;    // polynomial order
	localparam int HORNER_STEPS = ORDER;
	localparam int NUM_SETS = 4;

	// fraction bits dropped after each product, and for the final level
	localparam int HORNER_SHIFT = 16;
	localparam int LVL_SHIFT    = 12;

	// channel lanes
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// coefficient sets
	localparam logic [1:0] SET_RED_HI   = 2'd0;
	localparam logic [1:0] SET_GREEN_LO = 2'd1;
	localparam logic [1:0] SET_GREEN_HI = 2'd2;
	localparam logic [1:0] SET_BLUE_MID = 2'd3;

	// region knees in kelvin
	localparam logic [T_W-1:0] T_KNEE    = 16'd6600;
	localparam logic [T_W-1:0] T_BLUE_LO = 16'd2000;

	// x = floor((T*2^16 + 500) / 1000) by reciprocal plus one correction
	localparam int          N_W         = T_W + HORNER_SHIFT;
	localparam int          RECIP_W     = 31;
	localparam int          RECIP_SHIFT = 40;
	localparam logic [RECIP_W-1:0] RECIP_M = 31'd1099511627;   // floor(2^40/1000)
	localparam logic [N_W-1:0]     DIV_K      = 32'd1000;
	localparam logic [N_W-1:0]     ROUND_HALF = 32'd500;

	// constant levels
	localparam logic signed [LVL_W-1:0] LEVEL_ONE  = 16'sd4096;
	localparam logic signed [LVL_W-1:0] LEVEL_ZERO = 16'sd0;
	localparam logic signed [LVL_W-1:0] LEVEL_MAX  = 16'sh7fff;
	localparam logic signed [LVL_W-1:0] LEVEL_MIN  = 16'sh8000;

	typedef logic        [X_W-1:0]    x_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [LVL_W-1:0]  level_t;

	// which piece of each curve applies to a request
	typedef struct packed {
		logic red_one;    // T <= 6600: red is 1, green uses the low fit
		logic blue_zero;  // T <= 2000
		logic blue_one;   // T >= 6600
	} region_t;

	// Q.24 coefficients, [set][power of x]
	localparam coef_t COEF_TAB [NUM_SETS][ORDER+1] = '{
		'{-29'sd146347655,  29'sd115880231, -29'sd29796336,
		   29'sd3603746,   -29'sd211057,     29'sd4847},
		'{-29'sd2773274,    29'sd2800117,    29'sd835505,
		  -29'sd249813,     29'sd23891,     -29'sd771},
		'{ 29'sd36222009,  -29'sd5113695,    29'sd393929,
		  -29'sd15294,      29'sd293,       -29'sd2},
		'{ 29'sd4003044,   -29'sd6177371,    29'sd2598791,
		  -29'sd260718,     29'sd5998,       29'sd296}
	};

endpackage

// ----- src/bbrgb_horner_step.sv -----
// ---------------------------------------------------------------------------
// bbrgb_horner_step - one Horner step for all three channels, two stages
// acc' = sat40(floor((acc * x + 2^15) / 2^16) + c), acc split in two halves.
// ---------------------------------------------------------------------------
module bbrgb_horner_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  bbrgb_pkg::region_t  region,
	input  bbrgb_pkg::x_t       x,
	input  bbrgb_pkg::acc_t     acc  [bbrgb_pkg::NUM_CH],
	input  bbrgb_pkg::coef_t    coef [bbrgb_pkg::NUM_CH],
	output logic                res_valid,
	output bbrgb_pkg::region_t  res_region,
	output bbrgb_pkg::x_t       res_x,
	output bbrgb_pkg::acc_t     res_acc [bbrgb_pkg::NUM_CH]
);

	localparam int SPLIT = bbrgb_pkg::ACC_W / 2;
	localparam int HI_W  = bbrgb_pkg::ACC_W - SPLIT;
	localparam int LO_W  = SPLIT;
	localparam int PH_W  = HI_W + bbrgb_pkg::X_W + 1;
	localparam int LX_W  = LO_W + bbrgb_pkg::X_W;
	localparam int CS_W  = bbrgb_pkg::COEF_W + bbrgb_pkg::HORNER_SHIFT;
	localparam int PL_W  = ((LX_W > CS_W) ? LX_W : CS_W) + 2;
	localparam int SUM_W = PH_W + SPLIT;
	localparam int SH_W  = SUM_W - bbrgb_pkg::HORNER_SHIFT;

	logic signed [PH_W-1:0] ph_d [bbrgb_pkg::NUM_CH];
	logic signed [PL_W-1:0] pl_d [bbrgb_pkg::NUM_CH];
	bbrgb_pkg::acc_t        acc_d [bbrgb_pkg::NUM_CH];

	logic                   valid_s1;
	bbrgb_pkg::region_t     region_s1;
	bbrgb_pkg::x_t          x_s1;
	logic signed [PH_W-1:0] ph_s1 [bbrgb_pkg::NUM_CH];
	logic signed [PL_W-1:0] pl_s1 [bbrgb_pkg::NUM_CH];

	logic                   valid_s2;
	bbrgb_pkg::region_t     region_s2;
	bbrgb_pkg::x_t          x_s2;
	bbrgb_pkg::acc_t        acc_s2 [bbrgb_pkg::NUM_CH];

	// partial products; the coefficient and rounding half ride in the low part
	always_comb begin : mul_calc
		logic signed [HI_W-1:0]                ah;
		logic        [LO_W-1:0]                al;
		logic        [LX_W-1:0]                alx;
		logic signed [bbrgb_pkg::X_W:0]        xs;
		logic signed [PL_W-1:0]                cs;
		xs = $signed({1'b0, x});
		for (int ch = 0; ch < bbrgb_pkg::NUM_CH; ch++) begin
			ah  = acc[ch][bbrgb_pkg::ACC_W-1:SPLIT];
			al  = acc[ch][SPLIT-1:0];
			alx = LX_W'(al) * LX_W'(x);
			ph_d[ch] = PH_W'(ah) * PH_W'(xs);
			cs  = PL_W'(coef[ch]) <<< bbrgb_pkg::HORNER_SHIFT;
			pl_d[ch] = $signed(PL_W'(alx)) + cs
				+ $signed(PL_W'(1) <<< (bbrgb_pkg::HORNER_SHIFT - 1));
		end
	end

	// combine, drop fraction bits, saturate to the accumulator range
	always_comb begin : add_calc
		logic signed [SUM_W-1:0] sum;
		logic signed [SH_W-1:0]  sh;
		for (int ch = 0; ch < bbrgb_pkg::NUM_CH; ch++) begin
			sum = $signed({ph_s1[ch], {SPLIT{1'b0}}}) + SUM_W'(pl_s1[ch]);
			sh  = sum[SUM_W-1:bbrgb_pkg::HORNER_SHIFT];
			if ((&sh[SH_W-1:bbrgb_pkg::ACC_W-1]) || !(|sh[SH_W-1:bbrgb_pkg::ACC_W-1])) begin
				acc_d[ch] = sh[bbrgb_pkg::ACC_W-1:0];
			end else if (sh[SH_W-1]) begin
				acc_d[ch] = {1'b1, {(bbrgb_pkg::ACC_W-1){1'b0}}};
			end else begin
				acc_d[ch] = {1'b0, {(bbrgb_pkg::ACC_W-1){1'b1}}};
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		region_s1 <= region;
		x_s1      <= x;
		ph_s1     <= ph_d;
		pl_s1     <= pl_d;
		region_s2 <= region_s1;
		x_s2      <= x_s1;
		acc_s2    <= acc_d;
	end

	assign res_valid  = valid_s2;
	assign res_region = region_s2;
	assign res_x      = x_s2;
	assign res_acc    = acc_s2;

endmodule

// ----- src/blackbody_temperature_to_rgb_core.sv -----
// ---------------------------------------------------------------------------
// blackbody_temperature_to_rgb_core - color temperature to RGB levels
// Fifth-order polynomial fits in x = T/1000, evaluated by a pipelined Horner
// chain, three channels side by side.
//
//   channel   direction  signals                               handshake
//   request   in         temperature_k                         start, busy
//   result    out        red_level, green_level, blue_level    done
//
// One request per cycle; each result passes these stages in order:
// two stages form x (reciprocal multiply, then remainder correction), five
// Horner steps take two stages each, one stage rounds and selects.
// busy is always low; nothing in the pipe ever waits.
// Reset clears the valid bits only; data registers are not reset.
// ---------------------------------------------------------------------------
module blackbody_temperature_to_rgb_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic        [bbrgb_pkg::T_W-1:0]       temperature_k,
	output logic                                   done,
	output logic signed [bbrgb_pkg::LVL_W-1:0]     red_level,
	output logic signed [bbrgb_pkg::LVL_W-1:0]     green_level,
	output logic signed [bbrgb_pkg::LVL_W-1:0]     blue_level
);

	localparam int NSTEP   = bbrgb_pkg::HORNER_STEPS;
	localparam int NCH     = bbrgb_pkg::NUM_CH;
	localparam int PROD_W  = bbrgb_pkg::N_W + bbrgb_pkg::RECIP_W;
	localparam int LATENCY = 2 + 2 * NSTEP + 1;
	localparam int LR_W    = bbrgb_pkg::ACC_W + 1;
	localparam int LQ_W    = LR_W - bbrgb_pkg::LVL_SHIFT;

	// coefficient set of each lane
	function automatic logic [1:0] chan_set(input int unsigned ch, input logic green_lo);
		logic [1:0] s;
		if (ch == bbrgb_pkg::CH_RED) begin
			s = bbrgb_pkg::SET_RED_HI;
		end else if (ch == bbrgb_pkg::CH_BLUE) begin
			s = bbrgb_pkg::SET_BLUE_MID;
		end else if (green_lo) begin
			s = bbrgb_pkg::SET_GREEN_LO;
		end else begin
			s = bbrgb_pkg::SET_GREEN_HI;
		end
		return s;
	endfunction

	// Q15.24 accumulator to saturated Q3.12, round half up
	function automatic bbrgb_pkg::level_t to_level(input bbrgb_pkg::acc_t a);
		logic signed [LR_W-1:0] r;
		logic signed [LQ_W-1:0] l;
		r = LR_W'(a) + $signed(LR_W'(1) <<< (bbrgb_pkg::LVL_SHIFT - 1));
		l = r[LR_W-1:bbrgb_pkg::LVL_SHIFT];
		if ((&l[LQ_W-1:bbrgb_pkg::LVL_W-1]) || !(|l[LQ_W-1:bbrgb_pkg::LVL_W-1])) begin
			return l[bbrgb_pkg::LVL_W-1:0];
		end else if (l[LQ_W-1]) begin
			return bbrgb_pkg::LEVEL_MIN;
		end else begin
			return bbrgb_pkg::LEVEL_MAX;
		end
	endfunction

	logic                          accept;
	logic [bbrgb_pkg::N_W-1:0]     n_d;
	logic [PROD_W-1:0]             prod_d;
	bbrgb_pkg::region_t            region_d;

	logic                          valid_s1;
	logic [bbrgb_pkg::N_W-1:0]     n_s1;
	bbrgb_pkg::x_t                 q_est_s1;
	bbrgb_pkg::region_t            region_s1;

	logic [bbrgb_pkg::N_W-1:0]     qm_d;
	logic [bbrgb_pkg::N_W-1:0]     rem_d;
	bbrgb_pkg::x_t                 x_d;

	logic                          valid_s2;
	bbrgb_pkg::x_t                 x_s2;
	bbrgb_pkg::region_t            region_s2;

	logic                          c_valid  [NSTEP+1];
	bbrgb_pkg::region_t            c_region [NSTEP+1];
	bbrgb_pkg::x_t                 c_x      [NSTEP+1];
	bbrgb_pkg::acc_t               c_acc    [NSTEP+1][NCH];
	bbrgb_pkg::coef_t              c_coef   [NSTEP][NCH];

	bbrgb_pkg::level_t             lvl_d [NCH];
	logic                          done_q;
	bbrgb_pkg::level_t             red_q;
	bbrgb_pkg::level_t             green_q;
	bbrgb_pkg::level_t             blue_q;

	// the pipe never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: n = T*2^16 + 500, estimate n/1000 by reciprocal multiply
	assign n_d    = {temperature_k, {bbrgb_pkg::HORNER_SHIFT{1'b0}}} + bbrgb_pkg::ROUND_HALF;
	assign prod_d = PROD_W'(n_d) * PROD_W'(bbrgb_pkg::RECIP_M);

	always_comb begin
		region_d.red_one   = (temperature_k <= bbrgb_pkg::T_KNEE);
		region_d.blue_zero = (temperature_k <= bbrgb_pkg::T_BLUE_LO);
		region_d.blue_one  = (temperature_k >= bbrgb_pkg::T_KNEE);
	end

	// stage 2: the estimate is low by at most one; fix it from the remainder
	assign qm_d  = bbrgb_pkg::N_W'(q_est_s1) * bbrgb_pkg::DIV_K;
	assign rem_d = n_s1 - qm_d;
	assign x_d   = q_est_s1 + bbrgb_pkg::X_W'(rem_d >= bbrgb_pkg::DIV_K);

	// front stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// front stage payload
	always_ff @(posedge clk) begin
		n_s1      <= n_d;
		q_est_s1  <= prod_d[bbrgb_pkg::RECIP_SHIFT +: bbrgb_pkg::X_W];
		region_s1 <= region_d;
		x_s2      <= x_d;
		region_s2 <= region_s1;
	end

	// Horner chain head: accumulator starts at the top coefficient
	assign c_valid[0]  = valid_s2;
	assign c_region[0] = region_s2;
	assign c_x[0]      = x_s2;

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			c_acc[0][ch] = bbrgb_pkg::ACC_W'(
				bbrgb_pkg::COEF_TAB[chan_set(ch, region_s2.red_one)][bbrgb_pkg::ORDER]);
		end
	end

	// Horner steps, highest power first
	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		always_comb begin
			for (int ch = 0; ch < NCH; ch++) begin
				c_coef[j][ch] = bbrgb_pkg::COEF_TAB[chan_set(ch, c_region[j].red_one)]
					[bbrgb_pkg::ORDER - 1 - j];
			end
		end

		bbrgb_horner_step u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid      (c_valid[j]),
			.region     (c_region[j]),
			.x          (c_x[j]),
			.acc        (c_acc[j]),
			.coef       (c_coef[j]),
			.res_valid  (c_valid[j+1]),
			.res_region (c_region[j+1]),
			.res_x      (c_x[j+1]),
			.res_acc    (c_acc[j+1])
		);
	end

	// final rounding of each lane (x is not needed past the last step)
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			lvl_d[ch] = to_level(c_acc[NSTEP][ch]);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= c_valid[NSTEP];
		end
	end

	// result select by region
	always_ff @(posedge clk) begin
		red_q   <= c_region[NSTEP].red_one ? bbrgb_pkg::LEVEL_ONE : lvl_d[bbrgb_pkg::CH_RED];
		green_q <= lvl_d[bbrgb_pkg::CH_GREEN];
		if (c_region[NSTEP].blue_zero) begin
			blue_q <= bbrgb_pkg::LEVEL_ZERO;
		end else if (c_region[NSTEP].blue_one) begin
			blue_q <= bbrgb_pkg::LEVEL_ONE;
		end else begin
			blue_q <= lvl_d[bbrgb_pkg::CH_BLUE];
		end
	end

	assign done        = done_q;
	assign red_level   = red_q;
	assign green_level = green_q;
	assign blue_level  = blue_q;

	// every request comes out after the fixed latency, and only requests do
	a_req_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("request without result");

	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without request");

	// region handling follows the request's temperature
	a_red_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(temperature_k, LATENCY) <= bbrgb_pkg::T_KNEE)
		|-> red_level == bbrgb_pkg::LEVEL_ONE)
		else $error("red not at full level below knee");

	a_blue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(temperature_k, LATENCY) <= bbrgb_pkg::T_BLUE_LO)
		|-> blue_level == bbrgb_pkg::LEVEL_ZERO)
		else $error("blue not zero at low temperature");

	a_blue_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(temperature_k, LATENCY) >= bbrgb_pkg::T_KNEE)
		|-> blue_level == bbrgb_pkg::LEVEL_ONE)
		else $error("blue not at full level above knee");

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb - self-checking bench for blackbody_temperature_to_rgb_core
// Drives color temperature requests, with random idle gaps or back to back.
// Each accepted request is run through an integer Horner predictor of the
// three fixed-point color channels. Every done strobe is checked in order
// against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

	// channel triple as the core reports it
	typedef struct {
		bbrgb_pkg::level_t red;
		bbrgb_pkg::level_t green;
		bbrgb_pkg::level_t blue;
	} rgb_t;

	// polynomial fits, in the row order of fit_coef
	typedef enum int {FIT_RED_HI, FIT_GREEN_LO, FIT_GREEN_HI, FIT_BLUE_MID} fit_e;

	localparam longint ACC_HI     = (longint'(1) <<< 39) - 1;
	localparam longint ACC_LO     = -(longint'(1) <<< 39);
	localparam longint LVL_HI     = 32767;
	localparam longint LVL_LO     = -32768;
	localparam int     T_MAX      = 40000;
	localparam int     PIPE_DEPTH = 13;

	// Q.24 coefficients, [fit][power of x]
	localparam longint fit_coef [4][6] = '{
		'{-146347655, 115880231, -29796336, 3603746, -211057, 4847},
		'{-2773274, 2800117, 835505, -249813, 23891, -771},
		'{36222009, -5113695, 393929, -15294, 293, -2},
		'{4003044, -6177371, 2598791, -260718, 5998, 296}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [bbrgb_pkg::T_W-1:0]     temperature_k;
	logic                          done;
	bbrgb_pkg::level_t             red_level;
	bbrgb_pkg::level_t             green_level;
	bbrgb_pkg::level_t             blue_level;

	rgb_t pending_rgb [$];
	int   mismatch_count;
	bit   gaps_on;

	blackbody_temperature_to_rgb_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.temperature_k (temperature_k),
		.done          (done),
		.red_level     (red_level),
		.green_level   (green_level),
		.blue_level    (blue_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the core hangs
	initial begin
		#2000000;
		$display("blackbody_temperature_to_rgb_core verification failed");
		$finish;
	end

	// one fit by Horner's rule, accumulator clamped to signed Q15.24
	function automatic bbrgb_pkg::level_t horner_level(fit_e f, longint x);
		longint acc;
		longint lvl;
		int     k;
		acc = fit_coef[int'(f)][5];
		for (k = 4; k >= 0; k--) begin
			acc = ((acc * x + 32768) >>> 16) + fit_coef[int'(f)][k];
			if (acc > ACC_HI) acc = ACC_HI;
			if (acc < ACC_LO) acc = ACC_LO;
		end
		lvl = (acc + 2048) >>> 12;
		if (lvl > LVL_HI) lvl = LVL_HI;
		if (lvl < LVL_LO) lvl = LVL_LO;
		return bbrgb_pkg::level_t'(lvl);
	endfunction

	// expected channels for one temperature
	function automatic rgb_t rgb_for_temperature(logic [bbrgb_pkg::T_W-1:0] t);
		rgb_t   c;
		longint tk;
		longint x;
		tk = longint'(t);
		x  = (tk * 65536 + 500) / 1000;
		// 6600 K itself still counts as the low piece for red and green
		if (tk <= 6600) begin
			c.red   = bbrgb_pkg::LEVEL_ONE;
			c.green = horner_level(FIT_GREEN_LO, x);
		end else begin
			c.red   = horner_level(FIT_RED_HI, x);
			c.green = horner_level(FIT_GREEN_HI, x);
		end
		// blue: zero through 2000 K, fit strictly below 6600 K, one from there
		if (tk <= 2000)
			c.blue = bbrgb_pkg::LEVEL_ZERO;
		else if (tk < 6600)
			c.blue = horner_level(FIT_BLUE_MID, x);
		else
			c.blue = bbrgb_pkg::LEVEL_ONE;
		return c;
	endfunction

	function automatic void note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH @%0t: %s", $time, what);
	endfunction

	// request capture and result check, both on pre-edge values
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_rgb.push_back(rgb_for_temperature(temperature_k));
			if (done) begin
				if (pending_rgb.size() == 0) begin
					note_mismatch($sformatf("result with no request pending r=%0d g=%0d b=%0d",
						red_level, green_level, blue_level));
				end else begin
					want = pending_rgb.pop_front();
					if (red_level !== want.red)
						note_mismatch($sformatf("red exp %0d got %0d", want.red, red_level));
					if (green_level !== want.green)
						note_mismatch($sformatf("green exp %0d got %0d",
							want.green, green_level));
					if (blue_level !== want.blue)
						note_mismatch($sformatf("blue exp %0d got %0d", want.blue, blue_level));
				end
			end
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// drive one request and hold it until the core takes it
	task automatic send_temp(input int t);
		int n;
		start         <= 1'b1;
		temperature_k <= bbrgb_pkg::T_W'(t);
		@(posedge clk);
		while (busy) @(posedge clk);
		n = gap_len();
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending until every request has come back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_rgb.size() != 0) @(posedge clk);
	endtask

	// range ends, knees and their neighbors
	task automatic test_directed();
		int pts [$];
		pts = '{0, 1, 999, 1000, 1001, 1999, 2000, 2001, 2500, 4000, 6599, 6600,
			6601, 10000, 12000, 20000, 32767, 32768, 39999, T_MAX};
		foreach (pts[i]) send_temp(pts[i]);
		drain_results();
	endtask

	// uniform from 0 to T_MAX
	task automatic test_random_span(input int count);
		repeat (count) send_temp($urandom_range(0, T_MAX));
	endtask

	// around the 2000 K and 6600 K knees and inside the fitted band
	task automatic test_knees(input int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 2);
			case (r)
				0: send_temp(2000 + $urandom_range(0, 100) - 50);
				1: send_temp(6600 + $urandom_range(0, 100) - 50);
				default: send_temp($urandom_range(1000, 12000));
			endcase
		end
	endtask

	// top of the range, where the fits run far past their domain
	task automatic test_far_range(input int count);
		repeat (count) send_temp($urandom_range(32768, T_MAX));
	endtask

	// one request every cycle
	task automatic test_back_to_back(input int count);
		gaps_on = 1'b0;
		repeat (count) send_temp($urandom_range(0, T_MAX));
		gaps_on = 1'b1;
	endtask

	initial begin
		start          = 1'b0;
		temperature_k  = '0;
		arst_n         = 1'b0;
		mismatch_count = 0;
		gaps_on        = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_span(700);
		drain_results();
		test_knees(450);
		test_back_to_back(350);
		test_far_range(150);
		test_random_span(150);

		drain_results();
		repeat (PIPE_DEPTH + 7) @(posedge clk);
		if (mismatch_count == 0 && pending_rgb.size() == 0) begin
			$display("blackbody_temperature_to_rgb_core verification clean");
		end else begin
			$display("blackbody_temperature_to_rgb_core verification failed");
		end
		$finish;
	end

endmodule

// ----- blackbody_temperature_to_rgb_core.f -----
src/bbrgb_pkg.sv
src/bbrgb_horner_step.sv
src/blackbody_temperature_to_rgb_core.sv
verif/tb.sv
